// File: hw/rtl/lwpq_pkg.sv
// Shared types and codes for the lock wait priority queue.
// Used by lwpq_cell, lwpq_head and lock_wait_priority_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lwpq_pkg;

    // Request codes carried on the slave tuser
    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_REMOVE,
        CMD_PEEK
    } cmd_t;

    // Result status carried on the master tuser
    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_DUP,
        STATUS_ABSENT
    } status_t;

    // One queued waiter
    typedef struct packed {
        logic [5:0]         lock;
        logic [5:0]         proc;
        logic signed [15:0] prio;
        logic               kind;
        logic [31:0]        stamp;
    } entry_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic capture;    // latch compare flags against the incoming request
        logic shift_in;   // make room and insert the held request
        logic shift_out;  // close the gap left by the matched process
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/lwpq_cell.sv
// One cell of the sorted wait chain: holds an entry, compares it with a request
// and takes data from either neighbor or the held request. Depends on lwpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwpq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lwpq_pkg::cell_ctl_t ctl,
    input  wire lwpq_pkg::entry_t  req,          // request compared on capture
    input  wire lwpq_pkg::entry_t  new_entry,    // held request written on insert
    input  wire lwpq_pkg::entry_t  left_entry,
    input  wire logic              left_valid,
    input  wire logic              left_gt,
    input  wire lwpq_pkg::entry_t  right_entry,
    input  wire logic              right_valid,
    input  wire logic              pfx_in,       // process matched in an earlier cell
    input  wire logic              seen_in,      // lock matched in an earlier cell
    output lwpq_pkg::entry_t       entry,
    output logic                   valid,
    output logic                   gt,
    output logic                   pfx_out,
    output logic                   seen_out,
    output logic                   sel
);
    import lwpq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   gt_reg, proc_hit_reg, lock_hit_reg;

    // Pass match flags down the chain
    assign pfx_out  = pfx_in | proc_hit_reg;
    assign seen_out = seen_in | lock_hit_reg;
    assign sel      = lock_hit_reg & ~seen_in;
    assign gt       = gt_reg;
    assign entry    = entry_reg;
    assign valid    = valid_reg;

    // Choose the next content of this cell
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.shift_in)
        begin
            if (!left_gt)
            begin
                valid_next = left_valid;
                entry_next = left_entry;
            end
            else if (!gt_reg)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
        else if (ctl.shift_out && pfx_out)
        begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
    end

    // Hold compare flags and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            gt_reg       <= 1'b0;
            proc_hit_reg <= 1'b0;
            lock_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.capture)
            begin
                gt_reg       <= valid_reg && ($signed(entry_reg.prio) > $signed(req.prio));
                proc_hit_reg <= valid_reg && (entry_reg.proc == req.proc);
                lock_hit_reg <= valid_reg && (entry_reg.lock == req.lock);
            end
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lwpq_head.sv
// Head select: gathers the entry of the single cell flagged as the front of a
// lock's queue. Depends on lwpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwpq_head #(
    parameter int NUM_CELLS = 64
) (
    input  wire logic                 [NUM_CELLS-1:0] sel,
    input  wire lwpq_pkg::entry_t     cells [NUM_CELLS],
    output lwpq_pkg::entry_t          head,
    output logic                      found
);
    import lwpq_pkg::*;

    // AND-OR gather over the one-hot select
    always_comb
    begin
        head = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (sel[i])
                head = head | cells[i];
        end
    end

    assign found = |sel;

endmodule

`default_nettype wire

// File: hw/rtl/lock_wait_priority_queue.sv
// Lock wait priority queue, top level. Instantiates lwpq_cell and lwpq_head;
// depends on lwpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Wait queues for all locks held as one chain of NUM_PROCS cells sorted by
// priority, highest first; each lock's queue is the chain order restricted to
// its tag, and equal priorities are served last-in first-out. Requests come in
// on the slave stream (insert, remove by process id, peek at a lock's head) and
// each produces exactly one result on the master stream. A request is taken in
// the idle state: on acceptance every cell compares itself with it and stores
// the flags; in the evaluate state the match flags ripple along the chain, the
// cells shift by one place to insert or close a gap, and the result is loaded
// into the output register. Evaluation waits while an earlier result is still
// held, and no new request is taken until it completes. A duplicate insert and
// a remove of an absent process leave the queues untouched and are reported
// in the status. An insert whose process or lock id is beyond the configured
// range is dropped with status ok; a peek of such a lock reports empty.
module lock_wait_priority_queue #(
    parameter int NUM_PROCS = 64,
    parameter int NUM_LOCKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // lock_id[5:0], proc_id[11:6], wait_prio[27:12], access_kind[28], stamp[60:29]
    input  wire logic [63:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // is_empty[0], head_proc[6:1], head_prio[22:7], head_kind[23], head_stamp[55:24]
    output logic [55:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser
);
    import lwpq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    entry_t      item_reg, item_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [55:0] m_data_reg, m_data_next;

    entry_t      req;
    cell_ctl_t   ctl;
    logic        accept, go;
    logic        bad_ins, bad_lock, dup;

    entry_t      cell_entry [NUM_PROCS];
    logic [NUM_PROCS-1:0] valid_vec, gt_vec, sel_vec;
    logic [NUM_PROCS:0]   pfx_chain, seen_chain;
    entry_t      head;
    logic        head_found;

    // Unpack the incoming request
    assign req.lock  = s_axis_tdata[5:0];
    assign req.proc  = s_axis_tdata[11:6];
    assign req.prio  = s_axis_tdata[27:12];
    assign req.kind  = s_axis_tdata[28];
    assign req.stamp = s_axis_tdata[60:29];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign go            = (state_reg == ST_EVAL) && (!m_valid_reg || m_axis_tready);

    // Range checks and duplicate detection
    assign bad_ins  = ({3'b000, item_reg.proc} >= 9'(NUM_PROCS)) ||
                      ({3'b000, item_reg.lock} >= 9'(NUM_LOCKS));
    assign bad_lock = ({3'b000, item_reg.lock} >= 9'(NUM_LOCKS));
    assign dup      = pfx_chain[NUM_PROCS];

    // Drive the cells
    always_comb
    begin
        ctl.capture   = accept;
        ctl.shift_in  = go && (cmd_reg == CMD_INSERT) && !bad_ins && !dup;
        ctl.shift_out = go && (cmd_reg == CMD_REMOVE) && dup;
    end

    assign pfx_chain[0]  = 1'b0;
    assign seen_chain[0] = 1'b0;

    // Build the chain
    for (genvar i = 0; i < NUM_PROCS; i++)
    begin : g_cell
        entry_t l_entry, r_entry;
        logic   l_valid, l_gt, r_valid;

        if (i == 0)
        begin : g_first
            assign l_entry = item_reg;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b1;
        end
        else
        begin : g_mid
            assign l_entry = cell_entry[i-1];
            assign l_valid = valid_vec[i-1];
            assign l_gt    = gt_vec[i-1];
        end

        if (i == NUM_PROCS - 1)
        begin : g_last
            assign r_entry = item_reg;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner
            assign r_entry = cell_entry[i+1];
            assign r_valid = valid_vec[i+1];
        end

        lwpq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .req         (req),
            .new_entry   (item_reg),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .pfx_in      (pfx_chain[i]),
            .seen_in     (seen_chain[i]),
            .entry       (cell_entry[i]),
            .valid       (valid_vec[i]),
            .gt          (gt_vec[i]),
            .pfx_out     (pfx_chain[i+1]),
            .seen_out    (seen_chain[i+1]),
            .sel         (sel_vec[i])
        );
    end

    lwpq_head #(
        .NUM_CELLS (NUM_PROCS)
    ) u_head (
        .sel   (sel_vec),
        .cells (cell_entry),
        .head  (head),
        .found (head_found)
    );

    // Sequence the request and form the result
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        item_next     = item_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser);
                    item_next  = req;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (go)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_OK;
                    m_data_next   = '0;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!bad_ins && dup)
                                m_status_next = STATUS_DUP;
                        end
                        CMD_REMOVE:
                        begin
                            if (!dup)
                                m_status_next = STATUS_ABSENT;
                        end
                        CMD_PEEK:
                        begin
                            if (bad_lock || !head_found)
                                m_data_next[0] = 1'b1;
                            else
                                m_data_next = {head.stamp, head.kind, head.prio,
                                               head.proc, 1'b0};
                        end
                        default:
                        begin
                            m_status_next = STATUS_OK;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        item_reg     <= item_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_data_reg;

    // A result appears only out of the resolve cycle
    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_EVAL))
        else $error("result raised outside the resolve cycle");

    // At most one cell is the front of the peeked queue
    a_one_head: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_vec))
        else $error("more than one head cell selected");

    // Occupied cells stay packed at the front of the chain
    a_packed_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + {{NUM_PROCS{1'b0}}, 1'b1}))
        else $error("chain has a gap");

endmodule

`default_nettype wire

// File: test/lock_wait_priority_queue_tb.sv
// Self-checking testbench for lock_wait_priority_queue: random and directed
// insert/remove/peek requests with a scoreboard class that predicts each result.
// Depends on lwpq_pkg and the lock_wait_priority_queue RTL.
`timescale 1ns / 1ps

module lock_wait_priority_queue_tb;
    import lwpq_pkg::*;

    localparam int         NUM_SLOTS     = 64;
    localparam int         RANDOM_ITEMS  = 1900;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         MAX_REPORTS   = 60;
    localparam logic [1:0] CMD_SPARE     = 2'd3;

    // One result as it appears on {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        head_stamp;
        logic               head_kind;
        logic signed [15:0] head_prio;
        logic [5:0]         head_proc;
        logic               is_empty;
    } result_t;

    // Scoreboard: mirror of the waiter chain and the results still owed
    class lock_queue_scoreboard;
        entry_t  chain[NUM_SLOTS];
        int      depth = 0;
        int      peak_depth = 0;
        result_t owed_q[$];
        int      errors = 0;
        int      dup_cnt = 0;
        int      absent_cnt = 0;
        int      hit_cnt = 0;

        function int find_proc(logic [5:0] p);
            for (int i = 0; i < depth; i++)
                if (chain[i].proc == p)
                    return i;
            return -1;
        endfunction

        // Apply one accepted request to the mirror and queue its result
        function void note_request(logic [1:0] op, entry_t req);
            result_t res;
            int      pos;
            res = '0;
            if (op == CMD_INSERT) begin
                pos = find_proc(req.proc);
                if (pos >= 0) begin
                    res.status = STATUS_DUP;
                    dup_cnt++;
                end
                else begin
                    // go ahead of the first waiter with priority <= ours
                    pos = 0;
                    while (pos < depth && $signed(chain[pos].prio) > $signed(req.prio))
                        pos++;
                    for (int i = depth; i > pos; i--)
                        chain[i] = chain[i - 1];
                    chain[pos] = req;
                    depth++;
                    if (depth > peak_depth)
                        peak_depth = depth;
                end
            end
            else if (op == CMD_REMOVE) begin
                pos = find_proc(req.proc);
                if (pos < 0) begin
                    res.status = STATUS_ABSENT;
                    absent_cnt++;
                end
                else begin
                    for (int i = pos; i + 1 < depth; i++)
                        chain[i] = chain[i + 1];
                    depth--;
                end
            end
            else if (op == CMD_PEEK) begin
                res.is_empty = 1'b1;
                for (int i = 0; i < depth; i++) begin
                    if (chain[i].lock == req.lock) begin
                        res.is_empty   = 1'b0;
                        res.head_proc  = chain[i].proc;
                        res.head_prio  = chain[i].prio;
                        res.head_kind  = chain[i].kind;
                        res.head_stamp = chain[i].stamp;
                        hit_cnt++;
                        break;
                    end
                end
            end
            owed_q.push_back(res);
        endfunction

        function void flag_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_result(logic [1:0] st, logic [55:0] data);
            result_t got;
            result_t want;
            got = {st, data};
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, got);
                return;
            end
            want = owed_q.pop_front();
            flag_field("status",     want.status,     got.status);
            flag_field("is_empty",   want.is_empty,   got.is_empty);
            flag_field("head_proc",  want.head_proc,  got.head_proc);
            flag_field("head_prio",  want.head_prio,  got.head_prio);
            flag_field("head_kind",  want.head_kind,  got.head_kind);
            flag_field("head_stamp", want.head_stamp, got.head_stamp);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    lock_queue_scoreboard wq;
    int          cycle_cnt = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          op_cnt[4] = '{0, 0, 0, 0};
    logic [5:0]  hot_locks[4];

    lock_wait_priority_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Idle length per request; now and then run a stretch with no idling
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 17);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(input logic [1:0] op, input entry_t req);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, req.stamp, req.kind, req.prio, req.proc, req.lock};
        do
            @(posedge clk);
        while (!s_axis_tready);
        wq.note_request(op, req);
        op_cnt[op]++;
        @(negedge clk);
    endtask

    // Build one random request, mostly well formed against the current queues
    task automatic random_request();
        logic [1:0] op;
        entry_t     req;
        int         r;
        int         ins_share;
        int         tries;
        req.lock  = 6'($urandom_range(0, 63));
        req.proc  = 6'($urandom_range(0, 63));
        req.prio  = 16'($urandom);
        req.kind  = 1'($urandom);
        req.stamp = $urandom;
        ins_share = (wq.depth < 8) ? 55 : (wq.depth > 40) ? 20 : 40;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            op = CMD_SPARE;
        end
        else if (r < 3 + ins_share) begin
            op = CMD_INSERT;
            if ($urandom_range(0, 9) < 7)
                req.lock = hot_locks[$urandom_range(0, 3)];
            // favor ties and the extremes of the priority range
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: req.prio = 16'($urandom_range(0, 6) - 3);
                8:             req.prio = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                9:             req.prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:       ;
            endcase
            if (wq.depth > 0 && $urandom_range(0, 19) == 0) begin
                req.proc = wq.chain[$urandom_range(0, wq.depth - 1)].proc;
            end
            else begin
                tries = 0;
                while (wq.find_proc(req.proc) >= 0 && tries < 64) begin
                    req.proc = 6'($urandom_range(0, 63));
                    tries++;
                end
            end
        end
        else if (r < 33 + ins_share) begin
            op = CMD_REMOVE;
            if (wq.depth > 0 && $urandom_range(0, 9) < 8)
                req.proc = wq.chain[$urandom_range(0, wq.depth - 1)].proc;
        end
        else begin
            op = CMD_PEEK;
            r = $urandom_range(0, 9);
            if (wq.depth > 0 && r < 6)
                req.lock = wq.chain[$urandom_range(0, wq.depth - 1)].lock;
            else if (r < 8)
                req.lock = hot_locks[$urandom_range(0, 3)];
        end
        send_request(op, req);
    endtask

    // Result side: stall at random, then take one result
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = draw_gap(rx_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // Check every accepted result
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            wq.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, wq.owed_q.size());
            $display("lock_wait_priority_queue_tb: FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed requests, random requests, drain
    initial begin
        wq = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_INSERT;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queues, absent remove
        send_request(CMD_PEEK,   entry_t'{6'd0, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_REMOVE, entry_t'{6'd0, 6'd5, 16'h0000, 1'b0, 32'h0});
        // equal priorities: the later insert goes first
        send_request(CMD_INSERT, entry_t'{6'd0, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_INSERT, entry_t'{6'd0, 6'd1, 16'h0000, 1'b1, 32'hFFFFFFFF});
        send_request(CMD_PEEK,   entry_t'{6'd0, 6'd0, 16'h0000, 1'b0, 32'h0});
        // priority extremes on the top lock and process ids
        send_request(CMD_INSERT, entry_t'{6'd63, 6'd63, 16'h7FFF, 1'b1, 32'hA5A5A5A5});
        send_request(CMD_INSERT, entry_t'{6'd63, 6'd62, 16'h8000, 1'b0, 32'h5A5A5A5A});
        send_request(CMD_PEEK,   entry_t'{6'd63, 6'd0, 16'h0000, 1'b0, 32'h0});
        // duplicate insert, unused code with every bit set
        send_request(CMD_INSERT, entry_t'{6'd5, 6'd0, 16'h1234, 1'b1, 32'h12345678});
        send_request(CMD_SPARE,  entry_t'{6'h3F, 6'h3F, 16'hFFFF, 1'b1, 32'hFFFFFFFF});
        // lower priority behind, then remove the head
        send_request(CMD_INSERT, entry_t'{6'd0, 6'd2, 16'hFFFF, 1'b1, 32'h00000001});
        send_request(CMD_REMOVE, entry_t'{6'd0, 6'd1, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_PEEK,   entry_t'{6'd0, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_REMOVE, entry_t'{6'd0, 6'd1, 16'h0000, 1'b0, 32'h0});
        // drain the top lock
        send_request(CMD_REMOVE, entry_t'{6'd0, 6'd63, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_PEEK,   entry_t'{6'd63, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_REMOVE, entry_t'{6'd0, 6'd62, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_PEEK,   entry_t'{6'd63, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_PEEK,   entry_t'{6'd42, 6'd0, 16'h0000, 1'b0, 32'h0});
        // a higher priority on another lock must not change this lock's head
        send_request(CMD_INSERT, entry_t'{6'd1, 6'd10, 16'h7FFF, 1'b0, 32'h0000FFFF});
        send_request(CMD_PEEK,   entry_t'{6'd0, 6'd0, 16'h0000, 1'b0, 32'h0});
        send_request(CMD_PEEK,   entry_t'{6'd1, 6'd0, 16'h0000, 1'b0, 32'h0});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // rotate the set of busy locks now and then
            if (n % 200 == 0)
                for (int k = 0; k < 4; k++)
                    hot_locks[k] = 6'($urandom_range(0, 63));
            random_request();
        end
        s_axis_tvalid <= 1'b0;

        while (wq.owed_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d inserts (%0d duplicate), %0d removes (%0d absent), %0d spare",
                 op_cnt[CMD_INSERT], wq.dup_cnt, op_cnt[CMD_REMOVE], wq.absent_cnt,
                 op_cnt[CMD_SPARE]);
        $display("%0d peeks (%0d non-empty), deepest chain %0d waiters, %0d mismatches",
                 op_cnt[CMD_PEEK], wq.hit_cnt, wq.peak_depth, wq.errors);
        if (wq.errors == 0)
            $display("lock_wait_priority_queue_tb: PASS");
        else
            $display("lock_wait_priority_queue_tb: FAIL");
        $finish;
    end

endmodule

// File: lock_wait_priority_queue.f
hw/rtl/lwpq_pkg.sv
hw/rtl/lwpq_cell.sv
hw/rtl/lwpq_head.sv
hw/rtl/lock_wait_priority_queue.sv
test/lock_wait_priority_queue_tb.sv
